// ----- sv/csqa_pkg.sv -----
// Package for the control signal qualifier with auto-repeat.
// Holds register indexes, mode codes, delay defaults and the config struct.
// No dependencies.
package csqa_pkg;

  // Field widths
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned INDEX_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // Delay table: four registers, at most MAX_DELAYS entries in use
  localparam int unsigned DELAY_REGS = 4;
  localparam int unsigned MAX_DELAYS = 4;
  localparam int unsigned DELAY_LIM  = (MAX_DELAYS < DELAY_REGS) ? MAX_DELAYS : DELAY_REGS;

  localparam logic [COUNT_W-1:0] COUNT_LIM     = COUNT_W'(DELAY_LIM);
  localparam logic [COUNT_W-1:0] COUNT_DEFAULT = COUNT_W'(2);
  localparam logic [MS_W-1:0]    DEFAULT_LONG  = MS_W'(1000);
  localparam logic [MS_W-1:0]    DEFAULT_SHORT = MS_W'(100);
  localparam logic [MS_W-1:0]    TIMER_MAX     = '1;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_LEVEL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPEAT  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY3 = 3'd5;

  typedef logic [MS_W-1:0] ms_t;

  // Configuration handed from the register file to the update logic
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] count;
    ms_t [DELAY_REGS-1:0] delay;
  } cfg_t;

  // Per-control state carried between updates
  typedef struct packed {
    logic               was_held;
    ms_t                timer;
    logic [INDEX_W-1:0] index;
  } state_t;

endpackage

// ----- sv/csqa_cfg.sv -----
// Configuration register file for the auto-repeat qualifier.
// Depends on csqa_pkg.
module csqa_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [csqa_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [csqa_pkg::CFG_DAT_W-1:0] wr_data,
  output csqa_pkg::cfg_t                  cfg
);

  csqa_pkg::cfg_t cfg_r;
  csqa_pkg::cfg_t cfg_nxt;

  // Decode the register index; writes beyond the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        csqa_pkg::REG_MODE:   cfg_nxt.mode     = wr_data[csqa_pkg::MODE_W-1:0];
        csqa_pkg::REG_COUNT:  cfg_nxt.count    = wr_data[csqa_pkg::COUNT_W-1:0];
        csqa_pkg::REG_DELAY0: cfg_nxt.delay[0] = wr_data[csqa_pkg::MS_W-1:0];
        csqa_pkg::REG_DELAY1: cfg_nxt.delay[1] = wr_data[csqa_pkg::MS_W-1:0];
        csqa_pkg::REG_DELAY2: cfg_nxt.delay[2] = wr_data[csqa_pkg::MS_W-1:0];
        csqa_pkg::REG_DELAY3: cfg_nxt.delay[3] = wr_data[csqa_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/csqa_step.sv -----
// One update of the qualifier: fire output and next state from one input word.
// Purely combinational; depends on csqa_pkg.
module csqa_step #(
  parameter int unsigned MAX_DELAYS = csqa_pkg::MAX_DELAYS
) (
  input  csqa_pkg::cfg_t   cfg,
  input  csqa_pkg::state_t cur,
  input  logic             held,
  input  csqa_pkg::ms_t    elapsed_ms,
  output logic             fire,
  output csqa_pkg::state_t nxt
);

  // Entries usable: the smaller of MAX_DELAYS and the delay registers
  localparam int unsigned DELAY_LIM =
    (MAX_DELAYS < csqa_pkg::DELAY_REGS) ? MAX_DELAYS : csqa_pkg::DELAY_REGS;
  localparam logic [csqa_pkg::COUNT_W-1:0] COUNT_LIM = csqa_pkg::COUNT_W'(DELAY_LIM);

  logic [csqa_pkg::MS_W:0]        sum;
  csqa_pkg::ms_t                  timer_sat;
  logic [csqa_pkg::COUNT_W-1:0]   cnt;
  logic [csqa_pkg::INDEX_W-1:0]   last_idx;
  logic [csqa_pkg::INDEX_W-1:0]   idx;
  csqa_pkg::ms_t                  delay;
  logic                           press;
  logic                           due;

  // Saturating timer advance
  assign sum       = {1'b0, cur.timer} + {1'b0, elapsed_ms};
  assign timer_sat = sum[csqa_pkg::MS_W] ? csqa_pkg::TIMER_MAX : sum[csqa_pkg::MS_W-1:0];

  // Entries in use: default pair when zero, otherwise clamp to the table
  always_comb begin
    if (cfg.count == '0) begin
      cnt = csqa_pkg::COUNT_DEFAULT;
    end else if (cfg.count > COUNT_LIM) begin
      cnt = COUNT_LIM;
    end else begin
      cnt = cfg.count;
    end
  end

  assign last_idx = csqa_pkg::INDEX_W'(cnt - 3'd1);
  assign idx = ({1'b0, cur.index} >= cnt) ? last_idx : cur.index;

  // Current delay
  always_comb begin
    if (cfg.count == '0) begin
      delay = (idx == '0) ? csqa_pkg::DEFAULT_LONG : csqa_pkg::DEFAULT_SHORT;
    end else begin
      delay = cfg.delay[idx];
    end
  end

  assign press = held && !cur.was_held;
  assign due   = held && (timer_sat >= delay);

  // Mode select
  always_comb begin
    nxt.was_held = held;
    nxt.timer    = timer_sat;
    nxt.index    = cur.index;
    case (cfg.mode)
      csqa_pkg::MODE_LEVEL: begin
        fire = held;
      end
      csqa_pkg::MODE_REPEAT: begin
        fire      = press || due;
        nxt.index = idx;
        if (press) begin
          nxt.timer = '0;
          nxt.index = '0;
        end else if (due) begin
          nxt.timer = '0;
          nxt.index = ({1'b0, idx} + 3'd1 >= cnt) ? last_idx : idx + 2'd1;
        end
      end
      default: begin
        fire = cur.was_held && !held;
      end
    endcase
  end

endmodule

// ----- sv/control_signal_qualifier_autorepeat.sv -----
// Top level of the control signal qualifier with typematic auto-repeat.
// Depends on csqa_pkg, csqa_cfg and csqa_step.
//
//   channel | ports                          | direction | handshake
//   in      | in_held, in_elapsed_ms         | input     | in_valid / in_stall
//   out     | out_fire                       | output    | out_valid / out_stall
//   cfg     | cfg_index, cfg_data            | input     | cfg_valid / cfg_ready
//
// One word per cycle while out_stall is low. A word is latched into the input
// register and then updated through csqa_step into the result register once
// that register is empty or being drained. Synchronous active-low reset clears
// valid flags, state and the configuration registers; payload registers are
// not reset. out_stall holds the result register; the input register then
// holds too and in_stall rises while it is full.
module control_signal_qualifier_autorepeat #(
  parameter int unsigned MAX_DELAYS = csqa_pkg::MAX_DELAYS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_held,
  input  logic [csqa_pkg::MS_W-1:0]      in_elapsed_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_fire,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [csqa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csqa_pkg::CFG_DAT_W-1:0] cfg_data
);

  csqa_pkg::cfg_t   cfg;
  csqa_pkg::state_t state_r;
  csqa_pkg::state_t state_nxt;

  logic             in_valid_r;
  logic             in_held_r;
  csqa_pkg::ms_t    in_elapsed_r;
  logic             out_valid_r;
  logic             out_fire_r;
  logic             fire_nxt;
  logic             out_free;
  logic             step_en;
  logic             in_take;

  // Register file
  assign cfg_ready = 1'b1;

  csqa_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Update logic
  csqa_step #(
    .MAX_DELAYS (MAX_DELAYS)
  ) u_step (
    .cfg        (cfg),
    .cur        (state_r),
    .held       (in_held_r),
    .elapsed_ms (in_elapsed_r),
    .fire       (fire_nxt),
    .nxt        (state_nxt)
  );

  // Advance when the result register is empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign step_en  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_held_r    <= in_held;
      in_elapsed_r <= in_elapsed_ms;
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step_en) begin
        state_r <= state_nxt;
      end
      if (out_free) begin
        out_valid_r <= step_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_fire_r <= fire_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_fire  = out_fire_r;

  // Checks
  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_valid_r)
    else $error("update did not reach the result register");

  a_level_follows: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (cfg.mode == csqa_pkg::MODE_LEVEL) |=> out_fire_r == $past(in_held_r))
    else $error("level mode output differs from held");

  a_press_fires: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (cfg.mode == csqa_pkg::MODE_REPEAT) && in_held_r && !state_r.was_held
    |=> out_fire_r && (state_r.timer == '0) && (state_r.index == '0))
    else $error("press did not fire and restart the repeat timer");

endmodule
